// ----- sv/mmpl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmpl_pkg
// Types, constants and arithmetic helpers of the masked map pyramid level.
// ----------------------------------------------------------------------------
package mmpl_pkg;

    localparam int unsigned ROW_CNT_W = 10;
    localparam int unsigned SIZE_W    = 11;
    localparam int unsigned POS_W     = 9;
    localparam int unsigned VAL_W     = 18;
    localparam int unsigned TABLE_MAX = 100;

    localparam logic [2:0] ADDR_IN_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_IN_HEIGHT = 3'd4;

    localparam logic signed [VAL_W-1:0] UNKNOWN_Q16 = -18'sd65536;
    localparam logic [16:0]             HALF_Q16    = 17'd32768;

    // One column of the downsampled image seen by the vertical filter taps.
    typedef struct packed {
        logic signed [VAL_W-1:0] top;
        logic signed [VAL_W-1:0] mid;
        logic signed [VAL_W-1:0] bot;
    } col_t;

    localparam logic [16:0] TANH_Q16 [0:100] = '{
        17'd0, 17'd6532, 17'd12935, 17'd19091, 17'd24900, 17'd30285, 17'd35196,
        17'd39608, 17'd43518, 17'd46943, 17'd49912, 17'd52462, 17'd54634,
        17'd56474, 17'd58022, 17'd59320, 17'd60402, 17'd61303, 17'd62050,
        17'd62668, 17'd63179, 17'd63600, 17'd63946, 17'd64232, 17'd64466,
        17'd64659, 17'd64817, 17'd64947, 17'd65053, 17'd65140, 17'd65212,
        17'd65271, 17'd65319, 17'd65358, 17'd65390, 17'd65417, 17'd65438,
        17'd65456, 17'd65470, 17'd65482, 17'd65492, 17'd65500, 17'd65507,
        17'd65512, 17'd65516, 17'd65520, 17'd65523, 17'd65525, 17'd65527,
        17'd65529, 17'd65530, 17'd65531, 17'd65532, 17'd65533, 17'd65533,
        17'd65534, 17'd65534, 17'd65535, 17'd65535, 17'd65535, 17'd65535,
        17'd65535, 17'd65535, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536
    };

    // Unknown cells count as one half inside the blur.
    function automatic logic [16:0] known(input logic signed [VAL_W-1:0] v);
        return v[VAL_W-1] ? HALF_Q16 : v[16:0];
    endfunction

    function automatic logic [18:0] vsum(input col_t c);
        return {2'b00, known(c.top)} + {1'b0, known(c.mid), 1'b0} + {2'b00, known(c.bot)};
    endfunction

    function automatic logic signed [VAL_W-1:0] blur(input col_t l, input col_t c,
                                                      input col_t r);
        logic [20:0] s;
        s = {2'b00, vsum(l)} + {1'b0, vsum(c), 1'b0} + {2'b00, vsum(r)};
        return c.mid[VAL_W-1] ? UNKNOWN_Q16 : {1'b0, s[20:4]};
    endfunction

    function automatic logic signed [VAL_W-1:0] normalize(input logic signed [VAL_W-1:0] v);
        logic [23:0] prod;
        logic [7:0]  idx;
        prod = {7'd0, v[16:0]} * 24'd100;
        idx  = prod[23:16];
        if (idx > 8'(TABLE_MAX))
        begin
            idx = 8'(TABLE_MAX);
        end
        return v[VAL_W-1] ? UNKNOWN_Q16 : {1'b0, TANH_Q16[idx[6:0]]};
    endfunction

    // Column as seen one output row lower on the bottom border (reflect-101).
    function automatic col_t lower_of(input col_t c);
        col_t r;
        r.top = c.mid;
        r.mid = c.bot;
        r.bot = c.mid;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/masked_map_pyramid_level.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_map_pyramid_level
// Downsamples an occupancy map level 2x2 and applies a masked 3x3 blur.
// ----------------------------------------------------------------------------
// Input pixels arrive in raster order on pix_valid/pix_stall/occupancy_in, one
// item per cycle unless pix_stall holds them. Output pixels leave on
// res_valid/res_stall with their value, tanh-normalized value, column, row and
// a frame_last flag on the final one. Sizes are to be set through the APB port
// only while the block is idle; the block does not enforce this. A write to
// either size restarts the frame. An input item is taken into an input
// register; from there it is combined with the line buffers and, if it causes
// results, loads the result sequencer, which writes one result per cycle into
// the output register while the output is not stalled. With a receiver that
// takes every result, an input is accepted in every cycle: the sequencer makes
// one result per input that causes results (two on the bottom output row or at
// the last column, four at the bottom row's last column), and the next input
// that causes results is at least two items later. A stalled output holds its
// result; the sequencer and then the input side stall behind it. Reset sets
// both sizes to 1024 and starts a new frame; the line buffers need no clearing.
module masked_map_pyramid_level #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire  logic                clk,
    input  wire  logic                rst_n,
    input  wire  logic                psel,
    input  wire  logic                penable,
    input  wire  logic                pwrite,
    input  wire  logic [2:0]          paddr,
    input  wire  logic [31:0]         pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire  logic                pix_valid,
    output logic                      pix_stall,
    input  wire  logic signed [17:0]  occupancy_in,
    output logic                      res_valid,
    input  wire  logic                res_stall,
    output logic signed [17:0]        occupancy_out,
    output logic signed [17:0]        normalized_out,
    output logic [8:0]                out_col,
    output logic [8:0]                out_row,
    output logic                      frame_last
);

    localparam int unsigned CW   = $clog2(MAX_WIDTH);
    localparam int unsigned HW   = CW - 1;
    localparam int unsigned HALF = MAX_WIDTH / 2;
    localparam int unsigned W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    // Configuration
    logic [10:0]  width_reg, height_reg;
    logic [CW:0]  w_eff_reg, w_eff_next;
    logic [10:0]  h_eff_reg, h_eff_next;
    logic         cfg_wr;

    // Raster counters
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [9:0]    row_cnt_reg, row_cnt_next;
    logic          pix_acc;

    // Input register stage
    logic                  s1_valid_reg;
    logic signed [17:0]    s1_pix_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [9:0]            s1_row_reg;
    logic signed [17:0]    left_reg;
    logic signed [18:0]    pair_rd_reg;
    logic signed [17:0]    a_rd_reg, b_rd_reg;
    mmpl_pkg::col_t        win1_reg, win2_reg;

    // Line buffers
    logic signed [18:0]    pair_mem [0:HALF-1];
    logic signed [17:0]    down_a_mem [0:HALF-1];
    logic signed [17:0]    down_b_mem [0:HALF-1];

    // Result sequencer
    logic                  s2_valid_reg;
    mmpl_pkg::col_t        s2_l_reg, s2_c_reg, s2_r_reg;
    logic [1:0]            s2_step_reg, s2_last_reg;
    logic                  s2_lower_reg;
    logic [8:0]            s2_col_reg, s2_row_reg;

    // Output register
    logic                  out_valid_reg;
    logic signed [17:0]    occ_reg, norm_reg;
    logic [8:0]            ocol_reg, orow_reg;
    logic                  last_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {21'd0, height_reg} : {21'd0, width_reg};

    always_comb
    begin
        logic [31:0] wv, hv;
        wv = {21'd0, pwdata[10:0]};
        hv = {21'd0, pwdata[10:0]};
        if (wv < 32'd4)
        begin
            wv = 32'd4;
        end
        else if (wv > MAX_WIDTH)
        begin
            wv = MAX_WIDTH;
        end
        if (hv < 32'd4)
        begin
            hv = 32'd4;
        end
        else if (hv > 32'd1024)
        begin
            hv = 32'd1024;
        end
        w_eff_next = (CW+1)'(wv) & ~(CW+1)'(1);
        h_eff_next = hv[10:0] & ~11'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
            w_eff_reg  <= (CW+1)'(W_RST);
            h_eff_reg  <= 11'd1024;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == mmpl_pkg::ADDR_IN_HEIGHT[2])
            begin
                height_reg <= pwdata[10:0];
                h_eff_reg  <= h_eff_next;
            end
            else
            begin
                width_reg <= pwdata[10:0];
                w_eff_reg <= w_eff_next;
            end
        end
    end

    // ---------------- flow control ----------------
    logic [HW-1:0] s1_oc;
    logic [8:0]    s1_orow;
    logic          s1_emit, s1_move, s2_fire, s2_done, s2_free, out_free;

    assign s1_oc    = s1_col_reg[CW-1:1];
    assign s1_orow  = s1_row_reg[9:1];
    assign s1_emit  = s1_col_reg[0] && s1_row_reg[0] && (s1_orow != 9'd0) && (s1_oc != '0);
    assign out_free = !out_valid_reg || !res_stall;
    assign s2_fire  = s2_valid_reg && out_free;
    assign s2_done  = s2_fire && (s2_step_reg == s2_last_reg);
    assign s2_free  = !s2_valid_reg || s2_done;
    assign s1_move  = s1_valid_reg && (!s1_emit || s2_free);
    assign pix_stall = s1_valid_reg && !s1_move;
    assign pix_acc  = pix_valid && !pix_stall;

    // ---------------- raster counters ----------------
    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (({1'b0, col_cnt_reg} + (CW+1)'(1)) >= w_eff_reg)
        begin
            col_cnt_next = '0;
            row_cnt_next = (({1'b0, row_cnt_reg} + 11'd1) >= h_eff_reg) ? 10'd0
                                                                          : row_cnt_reg + 10'd1;
        end
        else
        begin
            col_cnt_next = col_cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (cfg_wr && !paddr[1] && !paddr[0])
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (pix_acc)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ---------------- input register and line buffer reads ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_pix_reg  <= occupancy_in;
            s1_col_reg  <= col_cnt_reg;
            s1_row_reg  <= row_cnt_reg;
            pair_rd_reg <= pair_mem[col_cnt_reg[CW-1:1]];
            a_rd_reg    <= down_a_mem[col_cnt_reg[CW-1:1]];
            b_rd_reg    <= down_b_mem[col_cnt_reg[CW-1:1]];
        end
    end

    // ---------------- 2x2 average and column assembly ----------------
    logic signed [18:0] pair;
    logic signed [19:0] quad;
    logic signed [17:0] d_val, same_rd, other_rd;
    mmpl_pkg::col_t     new_col;
    logic               odd_pair, win_shift;

    assign pair     = 19'(left_reg) + 19'(s1_pix_reg);
    assign quad     = 20'(pair_rd_reg) + 20'(pair);
    assign d_val    = quad[19:2];
    assign same_rd  = s1_orow[0] ? b_rd_reg : a_rd_reg;
    assign other_rd = s1_orow[0] ? a_rd_reg : b_rd_reg;
    assign odd_pair = s1_col_reg[0] && s1_row_reg[0];
    assign win_shift = s1_move && odd_pair && (s1_orow != 9'd0);

    always_comb
    begin
        new_col.top = (s1_orow == 9'd1) ? d_val : same_rd;
        new_col.mid = other_rd;
        new_col.bot = d_val;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && !s1_col_reg[0])
        begin
            left_reg <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_col_reg[0] && !s1_row_reg[0])
        begin
            pair_mem[s1_oc] <= pair;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && odd_pair && !s1_orow[0])
        begin
            down_a_mem[s1_oc] <= d_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && odd_pair && s1_orow[0])
        begin
            down_b_mem[s1_oc] <= d_val;
        end
    end

    // Window columns: after the shift win2 holds the newest column and win1 the one before it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win1_reg <= '0;
            win2_reg <= '0;
        end
        else if (win_shift)
        begin
            win1_reg <= win2_reg;
            win2_reg <= new_col;
        end
    end

    // ---------------- result sequencer ----------------
    logic          has_lower, has_extra;
    logic [HW-1:0] oc_m1;

    assign has_lower = (({1'b0, s1_orow} + 10'd1) == h_eff_reg[10:1]);
    assign has_extra = (({1'b0, s1_oc} + CW'(1)) == w_eff_reg[CW:1]);
    assign oc_m1     = s1_oc - HW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_step_reg  <= 2'd0;
        end
        else if (s1_move && s1_emit)
        begin
            s2_valid_reg <= 1'b1;
            s2_step_reg  <= 2'd0;
        end
        else if (s2_done)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_fire)
        begin
            s2_step_reg <= s2_step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_emit)
        begin
            // Left neighbor reflects onto the right one at the first column.
            s2_l_reg     <= (s1_oc == HW'(1)) ? new_col : win1_reg;
            s2_c_reg     <= win2_reg;
            s2_r_reg     <= new_col;
            s2_lower_reg <= has_lower;
            s2_last_reg  <= {has_extra && has_lower, has_extra || has_lower};
            s2_col_reg   <= 9'(oc_m1);
            s2_row_reg   <= s1_orow - 9'd1;
        end
    end

    // Results run upper/lower of the main column, then upper/lower of the
    // last column, which reflects its right neighbor onto its left.
    logic               is_extra, is_lower;
    mmpl_pkg::col_t     sel_l, sel_c, sel_r;
    logic signed [17:0] blur_val;

    assign is_extra = s2_lower_reg ? s2_step_reg[1] : s2_step_reg[0];
    assign is_lower = s2_lower_reg && s2_step_reg[0];

    always_comb
    begin
        if (is_extra)
        begin
            sel_l = s2_c_reg;
            sel_c = s2_r_reg;
            sel_r = s2_c_reg;
        end
        else
        begin
            sel_l = s2_l_reg;
            sel_c = s2_c_reg;
            sel_r = s2_r_reg;
        end
        if (is_lower)
        begin
            sel_l = mmpl_pkg::lower_of(sel_l);
            sel_c = mmpl_pkg::lower_of(sel_c);
            sel_r = mmpl_pkg::lower_of(sel_r);
        end
    end

    assign blur_val = mmpl_pkg::blur(sel_l, sel_c, sel_r);

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            occ_reg  <= blur_val;
            norm_reg <= mmpl_pkg::normalize(blur_val);
            ocol_reg <= s2_col_reg + {8'd0, is_extra};
            orow_reg <= s2_row_reg + {8'd0, is_lower};
            last_reg <= is_extra && is_lower;
        end
    end

    assign res_valid      = out_valid_reg;
    assign occupancy_out  = occ_reg;
    assign normalized_out = norm_reg;
    assign out_col        = ocol_reg;
    assign out_row        = orow_reg;
    assign frame_last     = last_reg;

    // ---------------- assertions ----------------
    a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !pix_stall)
        else $error("input stalled with empty input register");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_step_reg <= s2_last_reg))
        else $error("result sequencer step past its count");

    a_unknown_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && occ_reg[17]) |-> (norm_reg == mmpl_pkg::UNKNOWN_Q16))
        else $error("unknown value without unknown normalized value");

    a_last_lower: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && is_extra && is_lower) |=> (out_valid_reg && last_reg))
        else $error("final pixel not flagged");

endmodule
`default_nettype wire
